>>> src/mrtd_pkg.sv
package mrtd_pkg;

    localparam int DEF_DATA_BITS  = 50;
    localparam int DEF_ROW_LENGTH = 5;

    localparam int HDR_W   = 9;
    localparam int IV_W    = 16;
    localparam int ID_W    = 32;
    localparam int ADDR_W  = 5;
    localparam int PDATA_W = 32;

    // result status codes
    localparam logic [2:0] ST_IGNORED   = 3'd0;
    localparam logic [2:0] ST_STARTED   = 3'd1;
    localparam logic [2:0] ST_HALF      = 3'd2;
    localparam logic [2:0] ST_HEADER    = 3'd3;
    localparam logic [2:0] ST_DATA      = 3'd4;
    localparam logic [2:0] ST_TIME_RST  = 3'd5;
    localparam logic [2:0] ST_PAR_RST   = 3'd6;
    localparam logic [2:0] ST_TAG_DONE  = 3'd7;

    // tag verdict codes
    localparam logic [1:0] VD_EMPTY   = 2'd0;
    localparam logic [1:0] VD_KNOWN   = 2'd1;
    localparam logic [1:0] VD_UNKNOWN = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_SHORT_MIN = 3'd0;
    localparam logic [2:0] REG_SHORT_MAX = 3'd1;
    localparam logic [2:0] REG_LONG_MIN  = 3'd2;
    localparam logic [2:0] REG_LONG_MAX  = 3'd3;
    localparam logic [2:0] REG_TAG_A     = 3'd4;
    localparam logic [2:0] REG_TAG_B     = 3'd5;

    localparam logic [IV_W-1:0] RST_SHORT_MIN = 16'd200;
    localparam logic [IV_W-1:0] RST_SHORT_MAX = 16'd400;
    localparam logic [IV_W-1:0] RST_LONG_MIN  = 16'd400;
    localparam logic [IV_W-1:0] RST_LONG_MAX  = 16'd600;
    localparam logic [ID_W-1:0] RST_TAG_A     = 32'd285708;
    localparam logic [ID_W-1:0] RST_TAG_B     = 32'd16282433;

endpackage

>>> src/manchester_rfid_tag_decoder_unit.sv
// An accepted input word is held in the input register, then decoded
// into the result register.
// Throughput: one edge word per cycle while the result register is free or draining.
// Reset: synchronous, active low; clears decoder state and handshake valids,
// and loads the interval limits and known tag IDs with their defaults.
module manchester_rfid_tag_decoder_unit #(
    parameter int DATA_BITS  = mrtd_pkg::DEF_DATA_BITS,
    parameter int ROW_LENGTH = mrtd_pkg::DEF_ROW_LENGTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [mrtd_pkg::IV_W-1:0]    i_interval,
    input  logic                         i_edge_rising,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [2:0]                   o_status,
    output logic                         o_bit_value,
    output logic [mrtd_pkg::ID_W-1:0]    o_tag_id,
    output logic [1:0]                   o_verdict,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mrtd_pkg::ADDR_W-1:0]  paddr,
    input  logic [mrtd_pkg::PDATA_W-1:0] pwdata,
    output logic [mrtd_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import mrtd_pkg::*;

    localparam int CNT_W = $clog2(DATA_BITS + 1);
    localparam int POS_W = $clog2(ROW_LENGTH);
    localparam int CHK_W = (ROW_LENGTH > 1) ? ROW_LENGTH - 1 : 1;

    // configuration
    logic [IV_W-1:0] r_short_min, r_short_max, r_long_min, r_long_max;
    logic [ID_W-1:0] r_tag_a, r_tag_b;
    logic [2:0]      reg_idx;
    logic            cfg_wr;

    // input stage
    logic            r_in_valid;
    logic [IV_W-1:0] r_iv;
    logic            r_rise;
    logic            fire;

    // decoder state
    logic             r_timing, r_synced, r_await, r_hdr_done, r_level;
    logic [HDR_W-1:0] r_hdr;
    logic [CNT_W-1:0] r_cnt;
    logic [ROW_LENGTH-1:0] r_row;
    logic [POS_W-1:0] r_pos;
    logic [ID_W-1:0]  r_id;

    logic             n_timing, n_synced, n_await, n_hdr_done, n_level;
    logic [HDR_W-1:0] n_hdr;
    logic [CNT_W-1:0] n_cnt;
    logic [ROW_LENGTH-1:0] n_row;
    logic [POS_W-1:0] n_pos;
    logic [ID_W-1:0]  n_id;

    // result register
    logic            r_out_valid;
    logic [2:0]      r_status, n_status;
    logic            r_bitv, n_bitv;
    logic [ID_W-1:0] r_tag, n_tag;
    logic [1:0]      r_verdict, n_verdict;

    // decode helpers
    logic                  is_short, is_long, is_glitch;
    logic                  dec_bit, decoded, do_reset;
    logic [ROW_LENGTH-1:0] row_set;
    logic [POS_W:0]        pos_inc;
    logic [CHK_W-1:0]      chunk;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_min <= RST_SHORT_MIN;
            r_short_max <= RST_SHORT_MAX;
            r_long_min  <= RST_LONG_MIN;
            r_long_max  <= RST_LONG_MAX;
            r_tag_a     <= RST_TAG_A;
            r_tag_b     <= RST_TAG_B;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SHORT_MIN: r_short_min <= pwdata[IV_W-1:0];
                REG_SHORT_MAX: r_short_max <= pwdata[IV_W-1:0];
                REG_LONG_MIN:  r_long_min  <= pwdata[IV_W-1:0];
                REG_LONG_MAX:  r_long_max  <= pwdata[IV_W-1:0];
                REG_TAG_A:     r_tag_a     <= pwdata;
                REG_TAG_B:     r_tag_b     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SHORT_MIN: prdata = PDATA_W'(r_short_min);
            REG_SHORT_MAX: prdata = PDATA_W'(r_short_max);
            REG_LONG_MIN:  prdata = PDATA_W'(r_long_min);
            REG_LONG_MAX:  prdata = PDATA_W'(r_long_max);
            REG_TAG_A:     prdata = r_tag_a;
            REG_TAG_B:     prdata = r_tag_b;
            default:       prdata = '0;
        endcase
    end

    // handshake: the decode step fires when the result register is free or draining
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_iv   <= i_interval;
            r_rise <= i_edge_rising;
        end
    end

    always_comb begin
        is_short  = (r_short_min < r_iv) && (r_iv < r_short_max);
        is_long   = (r_long_min < r_iv) && (r_iv < r_long_max);
        is_glitch = (r_iv < r_short_min) || ((r_iv > r_short_max) && (r_iv < r_long_min));

        n_timing   = r_timing;
        n_synced   = r_synced;
        n_await    = r_await;
        n_hdr_done = r_hdr_done;
        n_level    = r_level;
        n_hdr      = r_hdr;
        n_cnt      = r_cnt;
        n_row      = r_row;
        n_pos      = r_pos;
        n_id       = r_id;

        n_status  = ST_IGNORED;
        n_bitv    = 1'b0;
        n_tag     = '0;
        n_verdict = VD_EMPTY;

        dec_bit  = 1'b0;
        decoded  = 1'b0;
        do_reset = 1'b0;

        row_set = '0;
        pos_inc = '0;
        chunk   = '0;

        priority if (!r_timing) begin
            n_timing = 1'b1;
            n_status = ST_STARTED;
        end else if (is_glitch) begin
            n_status = ST_IGNORED;
        end else if (!r_synced) begin
            if (is_long) begin
                n_synced = 1'b1;
                n_level  = r_rise;
                n_status = ST_HALF;
            end
        end else if (r_await) begin
            n_await = 1'b0;
            if (is_short) begin
                dec_bit = r_level;
                decoded = 1'b1;
            end else begin
                do_reset = 1'b1;
                n_status = ST_TIME_RST;
            end
        end else if (is_short) begin
            n_await  = 1'b1;
            n_status = ST_HALF;
        end else if (is_long) begin
            dec_bit = !r_level;
            decoded = 1'b1;
        end else begin
            do_reset = 1'b1;
            n_status = ST_TIME_RST;
        end

        if (decoded) begin
            n_level = dec_bit;
            priority if (!r_hdr_done) begin
                n_hdr = {r_hdr[HDR_W-2:0], dec_bit};
                if (&n_hdr) begin
                    n_hdr_done = 1'b1;
                    n_cnt      = '0;
                end
                n_status = ST_HEADER;
                n_bitv   = dec_bit;
            end else if (r_cnt < CNT_W'(DATA_BITS)) begin
                n_cnt    = r_cnt + 1'b1;
                row_set  = r_row | (ROW_LENGTH'(dec_bit) << r_pos);
                n_row    = row_set;
                n_status = ST_DATA;
                n_bitv   = dec_bit;
                pos_inc  = {1'b0, r_pos} + 1'b1;
                n_pos    = pos_inc[POS_W-1:0];
                if (pos_inc >= (POS_W+1)'(ROW_LENGTH)) begin
                    if (^row_set) begin
                        do_reset = 1'b1;
                        n_status = ST_PAR_RST;
                        n_bitv   = 1'b0;
                    end else begin
                        // first row bit lands highest in the shifted-in chunk
                        for (int k = 0; k < ROW_LENGTH - 1; k++) begin
                            chunk[ROW_LENGTH-2-k] = row_set[k];
                        end
                        n_id  = ID_W'({r_id, chunk[ROW_LENGTH-2:0]});
                        n_row = '0;
                        n_pos = '0;
                    end
                end
            end else begin
                n_tag    = r_id;
                n_status = ST_TAG_DONE;
                do_reset = 1'b1;
                if (r_id == ID_W'(0) || r_id == ID_W'(1)) begin
                    n_verdict = VD_EMPTY;
                end else if (r_id == r_tag_a || r_id == r_tag_b) begin
                    n_verdict = VD_KNOWN;
                end else begin
                    n_verdict = VD_UNKNOWN;
                end
            end
        end

        // decoder reset keeps the current level
        if (do_reset) begin
            n_timing   = 1'b0;
            n_synced   = 1'b0;
            n_await    = 1'b0;
            n_hdr_done = 1'b0;
            n_hdr      = '0;
            n_cnt      = '0;
            n_row      = '0;
            n_pos      = '0;
            n_id       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing   <= 1'b0;
            r_synced   <= 1'b0;
            r_await    <= 1'b0;
            r_hdr_done <= 1'b0;
            r_level    <= 1'b0;
            r_hdr      <= '0;
            r_cnt      <= '0;
            r_row      <= '0;
            r_pos      <= '0;
            r_id       <= '0;
        end else if (fire) begin
            r_timing   <= n_timing;
            r_synced   <= n_synced;
            r_await    <= n_await;
            r_hdr_done <= n_hdr_done;
            r_level    <= n_level;
            r_hdr      <= n_hdr;
            r_cnt      <= n_cnt;
            r_row      <= n_row;
            r_pos      <= n_pos;
            r_id       <= n_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status  <= n_status;
            r_bitv    <= n_bitv;
            r_tag     <= n_tag;
            r_verdict <= n_verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_bit_value = r_bitv;
    assign o_tag_id    = r_tag;
    assign o_verdict   = r_verdict;

endmodule
